FILE: rtl/core/sm4v_pkg.sv
package sm4v_pkg;

  localparam int WORD_W   = 32;
  localparam int HALF_W   = 64;
  localparam int KEY_CNT  = 32;
  localparam int KIDX_W   = 5;
  localparam int CFG_IDX_W = 2;

  typedef logic [WORD_W-1:0] word_t;
  typedef logic [HALF_W-1:0] half_t;
  typedef logic [KIDX_W-1:0] kidx_t;
  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

  localparam cfg_idx_t REG_KEY_HIGH = 2'd0;
  localparam cfg_idx_t REG_KEY_LOW  = 2'd1;

  localparam word_t FK0 = 32'ha3b1bac6;
  localparam word_t FK1 = 32'h56aa3350 ^ 32'h12345678;
  localparam word_t FK2 = 32'h677d9197;
  localparam word_t FK3 = 32'hb27022dc ^ 32'h9abcdef0;

  // Substitution table with the four swapped entries already in place.
  localparam logic [7:0] SBOX [256] = '{
    8'hd6,8'h90,8'he9,8'hfe,8'hcc,8'he1,8'h3d,8'hb7,8'h16,8'hb6,8'h14,8'hc2,8'h28,8'hfb,8'h2c,8'h05,
    8'h2b,8'h67,8'h9a,8'h76,8'h2a,8'hbe,8'h04,8'hc3,8'haa,8'h44,8'h13,8'h26,8'h49,8'h86,8'h06,8'h99,
    8'h9c,8'h42,8'h50,8'hf4,8'h91,8'hef,8'h98,8'h7a,8'h33,8'h54,8'h0b,8'h43,8'hed,8'hcf,8'hac,8'h62,
    8'he4,8'hb3,8'h1c,8'ha9,8'hc9,8'h08,8'he8,8'h95,8'h80,8'hdf,8'h7f,8'hfa,8'h75,8'h8f,8'h3f,8'ha6,
    8'h47,8'h07,8'ha7,8'hfc,8'hf3,8'h73,8'h17,8'hba,8'h83,8'h59,8'h3c,8'h19,8'he6,8'h85,8'h4f,8'ha8,
    8'h68,8'h6b,8'h81,8'hb2,8'h71,8'h64,8'hda,8'h8b,8'hf8,8'heb,8'h0f,8'h4b,8'h70,8'h56,8'h9d,8'h35,
    8'h1e,8'h24,8'h0e,8'h5e,8'h63,8'h58,8'hd1,8'ha2,8'h25,8'h22,8'h7c,8'h3b,8'h01,8'h21,8'h78,8'h87,
    8'hd4,8'h00,8'h46,8'h57,8'h9f,8'hd3,8'h27,8'h52,8'h4c,8'h36,8'h02,8'he7,8'ha0,8'hc4,8'hc8,8'h3a,
    8'hea,8'hbf,8'h8a,8'hd2,8'h40,8'hc7,8'h38,8'hb5,8'ha3,8'hf7,8'hf2,8'hce,8'hf9,8'h61,8'h15,8'ha1,
    8'he0,8'hae,8'h5d,8'ha4,8'h9b,8'h34,8'h1a,8'h55,8'had,8'h93,8'h32,8'h30,8'hf5,8'h8c,8'hb1,8'he3,
    8'h1d,8'hf6,8'he2,8'h2e,8'h82,8'h66,8'hca,8'h60,8'hc0,8'h29,8'h23,8'hab,8'h0d,8'h53,8'h4e,8'h6f,
    8'hd5,8'hdb,8'he8,8'h45,8'hde,8'hfd,8'h8e,8'h2f,8'h03,8'hff,8'h6a,8'h72,8'h6d,8'h6c,8'h5b,8'h51,
    8'h8d,8'h1b,8'haf,8'h92,8'hbb,8'hdd,8'hbc,8'h7f,8'h11,8'hd9,8'h5c,8'h41,8'h1f,8'h10,8'h5a,8'hd8,
    8'h0a,8'hc1,8'h31,8'h88,8'ha5,8'hcd,8'h7b,8'hbd,8'h2d,8'h74,8'hd0,8'h12,8'hb8,8'he5,8'hb4,8'hb0,
    8'h89,8'h69,8'h97,8'h4a,8'h0c,8'h96,8'h77,8'h7e,8'hb2,8'hb9,8'hf1,8'h09,8'hc5,8'h6e,8'hc6,8'h84,
    8'h18,8'hf0,8'h7d,8'hec,8'h3a,8'hdc,8'h4d,8'h20,8'h79,8'hee,8'h5f,8'h3e,8'hd7,8'h50,8'h66,8'h82
  };

  function automatic word_t sub32(input word_t x);
    return {SBOX[x[31:24]], SBOX[x[23:16]], SBOX[x[15:8]], SBOX[x[7:0]]};
  endfunction

  // Byte j of CK word i is (4i+j)*7 mod 256; the word is then rotated left by one.
  function automatic word_t ck_word(input kidx_t idx);
    word_t      w;
    logic [7:0] b;
    w = '0;
    for (int j = 0; j < 4; j++) begin
      b = 8'({1'b0, idx, 2'(j)} * 8'd7);
      w = {w[23:0], b};
    end
    return {w[30:0], w[31]};
  endfunction

endpackage

FILE: rtl/core/sm4v_round.sv
module sm4v_round (
  input  logic           key_mode,
  input  sm4v_pkg::word_t a0,
  input  sm4v_pkg::word_t a1,
  input  sm4v_pkg::word_t a2,
  input  sm4v_pkg::word_t a3,
  input  sm4v_pkg::word_t rk,
  output sm4v_pkg::word_t nx
);

  sm4v_pkg::word_t b;
  sm4v_pkg::word_t lin_key;
  sm4v_pkg::word_t lin_data;

  assign b = sm4v_pkg::sub32(a1 ^ a2 ^ a3 ^ rk);

  assign lin_key  = b ^ {b[18:0], b[31:19]} ^ {b[8:0], b[31:9]};
  assign lin_data = b ^ {b[29:0], b[31:30]} ^ {b[21:0], b[31:22]}
                      ^ {b[13:0], b[31:14]} ^ {b[7:0], b[31:8]};

  assign nx = a0 ^ (key_mode ? lin_key : lin_data);

endmodule

FILE: rtl/core/sm4_variant_block_encrypt_top.sv
// Encrypts one 128-bit block per accepted beat, ECB, with modified SM4 constants.
// A beat is taken only while the block is idle. After reset or any key register
// write, the next block first expands the 32 round keys, one per cycle,
// into a register file. Each block then runs ROUND_COUNT rounds, one per cycle
// through a single shared round unit (S-box plus linear mix), so the next block
// is accepted only once the last round of this one has finished.
// The result sits in an output register; a stalled result holds the last round.
module sm4_variant_block_encrypt_top #(
  parameter int ROUND_COUNT = 32
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  sm4v_pkg::half_t          in_block_high,
  input  sm4v_pkg::half_t          in_block_low,
  output logic                     out_valid,
  input  logic                     out_stall,
  output sm4v_pkg::half_t          out_cipher_high,
  output sm4v_pkg::half_t          out_cipher_low,
  input  logic                     cfg_valid,
  output logic                     cfg_ready,
  input  sm4v_pkg::cfg_idx_t       cfg_index,
  input  sm4v_pkg::half_t          cfg_data
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_KEYX = 2'd1;
  localparam logic [1:0] ST_RUN  = 2'd2;

  localparam sm4v_pkg::kidx_t LAST_KEY   = sm4v_pkg::kidx_t'(sm4v_pkg::KEY_CNT - 1);
  localparam sm4v_pkg::kidx_t LAST_ROUND = sm4v_pkg::kidx_t'(ROUND_COUNT - 1);

  logic [1:0]         state_r, state_nxt;
  sm4v_pkg::kidx_t    cnt_r, cnt_nxt;
  logic               keys_ready_r;
  sm4v_pkg::half_t    key_high_r, key_low_r;
  sm4v_pkg::word_t    rk_r [sm4v_pkg::KEY_CNT];
  sm4v_pkg::word_t    x_r [4];
  sm4v_pkg::word_t    k_r [4];
  logic               out_valid_r;
  sm4v_pkg::half_t    out_high_r, out_low_r;

  logic               in_take, out_take, cfg_take, finish, key_mode;
  sm4v_pkg::word_t    a0, a1, a2, a3, rk_sel, nx;

  assign in_take   = in_valid && !in_stall;
  assign out_take  = out_valid_r && !out_stall;
  assign cfg_take  = cfg_valid && cfg_ready;
  assign in_stall  = (state_r != ST_IDLE);
  assign cfg_ready = (state_r == ST_IDLE);
  assign key_mode  = (state_r == ST_KEYX);
  assign finish    = (state_r == ST_RUN) && (cnt_r == LAST_ROUND)
                     && (!out_valid_r || !out_stall);

  always_comb begin
    if (key_mode) begin
      a0 = k_r[0]; a1 = k_r[1]; a2 = k_r[2]; a3 = k_r[3];
      rk_sel = sm4v_pkg::ck_word(cnt_r);
    end else begin
      a0 = x_r[0]; a1 = x_r[1]; a2 = x_r[2]; a3 = x_r[3];
      rk_sel = rk_r[cnt_r];
    end
  end

  sm4v_round u_round (
    .key_mode (key_mode),
    .a0       (a0),
    .a1       (a1),
    .a2       (a2),
    .a3       (a3),
    .rk       (rk_sel),
    .nx       (nx)
  );

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_take) begin
          state_nxt = keys_ready_r ? ST_RUN : ST_KEYX;
          cnt_nxt   = '0;
        end
      end
      ST_KEYX: begin
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == LAST_KEY) begin
          state_nxt = ST_RUN;
        end
      end
      ST_RUN: begin
        if (finish) begin
          state_nxt = ST_IDLE;
        end else if (cnt_r != LAST_ROUND) begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      cnt_r        <= '0;
      keys_ready_r <= 1'b0;
      key_high_r   <= '0;
      key_low_r    <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      if (cfg_take && cfg_index == sm4v_pkg::REG_KEY_HIGH) begin
        key_high_r   <= cfg_data;
        keys_ready_r <= 1'b0;
      end else if (cfg_take && cfg_index == sm4v_pkg::REG_KEY_LOW) begin
        key_low_r    <= cfg_data;
        keys_ready_r <= 1'b0;
      end else if (key_mode && cnt_r == LAST_KEY) begin
        keys_ready_r <= 1'b1;
      end
      if (finish) begin
        out_valid_r <= 1'b1;
      end else if (out_take) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      x_r[0] <= in_block_high[63:32];
      x_r[1] <= in_block_high[31:0];
      x_r[2] <= in_block_low[63:32];
      x_r[3] <= in_block_low[31:0];
      k_r[0] <= key_high_r[63:32] ^ sm4v_pkg::FK0;
      k_r[1] <= key_high_r[31:0]  ^ sm4v_pkg::FK1;
      k_r[2] <= key_low_r[63:32]  ^ sm4v_pkg::FK2;
      k_r[3] <= key_low_r[31:0]   ^ sm4v_pkg::FK3;
    end else if (key_mode) begin
      k_r[0] <= k_r[1];
      k_r[1] <= k_r[2];
      k_r[2] <= k_r[3];
      k_r[3] <= nx;
      rk_r[cnt_r] <= nx;
    end else if (state_r == ST_RUN && cnt_r != LAST_ROUND) begin
      x_r[0] <= x_r[1];
      x_r[1] <= x_r[2];
      x_r[2] <= x_r[3];
      x_r[3] <= nx;
    end
    // Reverse word order on the way out.
    if (finish) begin
      out_high_r <= {nx, x_r[3]};
      out_low_r  <= {x_r[2], x_r[1]};
    end
  end

  assign out_valid       = out_valid_r;
  assign out_cipher_high = out_high_r;
  assign out_cipher_low  = out_low_r;

  a_run_needs_keys: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_RUN |-> keys_ready_r)
    else $error("rounds running without expanded keys");

  a_keyx_to_run: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_KEYX && cnt_r == LAST_KEY) |=> (keys_ready_r && state_r == ST_RUN))
    else $error("key expansion did not hand over to the rounds");

  a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_take |=> (state_r != ST_IDLE))
    else $error("accepted block did not start work");

  a_result_from_run: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> ($past(state_r) == ST_RUN && state_r == ST_IDLE))
    else $error("result appeared outside the last round");

endmodule

FILE: test/sm4v_cipher_checker.sv
module sm4v_cipher_checker
  import sm4v_pkg::*;
#(
  parameter int ROUND_COUNT = 32
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  input  logic     in_stall,
  input  half_t    in_block_high,
  input  half_t    in_block_low,
  input  logic     out_valid,
  input  logic     out_stall,
  input  half_t    out_cipher_high,
  input  half_t    out_cipher_low,
  input  logic     cfg_valid,
  input  logic     cfg_ready,
  input  cfg_idx_t cfg_index,
  input  half_t    cfg_data,
  output int       mismatches,
  output int       blocks_due
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    half_t high;
    half_t low;
  } cipher_t;

  // Substitution table, with 0x3A/0x7F and 0xB2/0xE8 swapped.
  localparam logic [7:0] SUBST [256] = '{
    'hd6,'h90,'he9,'hfe,'hcc,'he1,'h3d,'hb7,'h16,'hb6,'h14,'hc2,'h28,'hfb,'h2c,'h05,
    'h2b,'h67,'h9a,'h76,'h2a,'hbe,'h04,'hc3,'haa,'h44,'h13,'h26,'h49,'h86,'h06,'h99,
    'h9c,'h42,'h50,'hf4,'h91,'hef,'h98,'h7a,'h33,'h54,'h0b,'h43,'hed,'hcf,'hac,'h62,
    'he4,'hb3,'h1c,'ha9,'hc9,'h08,'he8,'h95,'h80,'hdf,'h7f,'hfa,'h75,'h8f,'h3f,'ha6,
    'h47,'h07,'ha7,'hfc,'hf3,'h73,'h17,'hba,'h83,'h59,'h3c,'h19,'he6,'h85,'h4f,'ha8,
    'h68,'h6b,'h81,'hb2,'h71,'h64,'hda,'h8b,'hf8,'heb,'h0f,'h4b,'h70,'h56,'h9d,'h35,
    'h1e,'h24,'h0e,'h5e,'h63,'h58,'hd1,'ha2,'h25,'h22,'h7c,'h3b,'h01,'h21,'h78,'h87,
    'hd4,'h00,'h46,'h57,'h9f,'hd3,'h27,'h52,'h4c,'h36,'h02,'he7,'ha0,'hc4,'hc8,'h3a,
    'hea,'hbf,'h8a,'hd2,'h40,'hc7,'h38,'hb5,'ha3,'hf7,'hf2,'hce,'hf9,'h61,'h15,'ha1,
    'he0,'hae,'h5d,'ha4,'h9b,'h34,'h1a,'h55,'had,'h93,'h32,'h30,'hf5,'h8c,'hb1,'he3,
    'h1d,'hf6,'he2,'h2e,'h82,'h66,'hca,'h60,'hc0,'h29,'h23,'hab,'h0d,'h53,'h4e,'h6f,
    'hd5,'hdb,'he8,'h45,'hde,'hfd,'h8e,'h2f,'h03,'hff,'h6a,'h72,'h6d,'h6c,'h5b,'h51,
    'h8d,'h1b,'haf,'h92,'hbb,'hdd,'hbc,'h7f,'h11,'hd9,'h5c,'h41,'h1f,'h10,'h5a,'hd8,
    'h0a,'hc1,'h31,'h88,'ha5,'hcd,'h7b,'hbd,'h2d,'h74,'hd0,'h12,'hb8,'he5,'hb4,'hb0,
    'h89,'h69,'h97,'h4a,'h0c,'h96,'h77,'h7e,'hb2,'hb9,'hf1,'h09,'hc5,'h6e,'hc6,'h84,
    'h18,'hf0,'h7d,'hec,'h3a,'hdc,'h4d,'h20,'h79,'hee,'h5f,'h3e,'hd7,'h50,'h66,'h82
  };

  localparam word_t KEY_WHITEN [4] = '{
    32'ha3b1bac6, 32'h56aa3350 ^ 32'h12345678,
    32'h677d9197, 32'hb27022dc ^ 32'h9abcdef0
  };

  half_t   key_high_q;
  half_t   key_low_q;
  word_t   round_key [KEY_CNT];
  bit      schedule_valid;
  cipher_t cipher_due [$];
  cipher_t due_head;

  function automatic word_t rol(input word_t x, input int n);
    return (x << n) | (x >> (WORD_W - n));
  endfunction

  function automatic word_t subst_word(input word_t x);
    return {SUBST[x[31:24]], SUBST[x[23:16]], SUBST[x[15:8]], SUBST[x[7:0]]};
  endfunction

  // Byte j of schedule constant i is (4i+j)*7 mod 256, then the word turns left by one.
  function automatic word_t schedule_const(input int i);
    word_t w;
    w = '0;
    for (int j = 0; j < 4; j++) w = {w[23:0], 8'((4 * i + j) * 7)};
    return rol(w, 1);
  endfunction

  function automatic void expand_schedule();
    word_t k [4];
    word_t b;
    word_t nk;
    k[0] = key_high_q[63:32] ^ KEY_WHITEN[0];
    k[1] = key_high_q[31:0]  ^ KEY_WHITEN[1];
    k[2] = key_low_q[63:32]  ^ KEY_WHITEN[2];
    k[3] = key_low_q[31:0]   ^ KEY_WHITEN[3];
    for (int i = 0; i < KEY_CNT; i++) begin
      b  = subst_word(k[1] ^ k[2] ^ k[3] ^ schedule_const(i));
      nk = k[0] ^ b ^ rol(b, 13) ^ rol(b, 23);
      round_key[i] = nk;
      k[0] = k[1];
      k[1] = k[2];
      k[2] = k[3];
      k[3] = nk;
    end
    schedule_valid = 1'b1;
  endfunction

  function automatic cipher_t cipher_block(input half_t hi, input half_t lo);
    word_t x [4];
    word_t b;
    word_t nx;
    x[0] = hi[63:32];
    x[1] = hi[31:0];
    x[2] = lo[63:32];
    x[3] = lo[31:0];
    for (int i = 0; i < ROUND_COUNT; i++) begin
      b  = subst_word(x[1] ^ x[2] ^ x[3] ^ round_key[i % KEY_CNT]);
      nx = x[0] ^ b ^ rol(b, 2) ^ rol(b, 10) ^ rol(b, 18) ^ rol(b, 24);
      x[0] = x[1];
      x[1] = x[2];
      x[2] = x[3];
      x[3] = nx;
    end
    // Words leave in reversed order.
    return '{high: {x[3], x[2]}, low: {x[1], x[0]}};
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      key_high_q     = '0;
      key_low_q      = '0;
      schedule_valid = 1'b0;
      cipher_due.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_KEY_HIGH: begin
            key_high_q     = cfg_data;
            schedule_valid = 1'b0;
          end
          REG_KEY_LOW: begin
            key_low_q      = cfg_data;
            schedule_valid = 1'b0;
          end
          default: ;
        endcase
      end
      if (out_valid && !out_stall) begin
        if (cipher_due.size() == 0) begin
          mismatches++;
          $display("%0t: cipher beat with nothing pending, got %h %h",
                   $time, out_cipher_high, out_cipher_low);
        end else begin
          due_head = cipher_due.pop_front();
          if (out_cipher_high !== due_head.high) begin
            mismatches++;
            $display("%0t: cipher_high expected %h got %h",
                     $time, due_head.high, out_cipher_high);
          end
          if (out_cipher_low !== due_head.low) begin
            mismatches++;
            $display("%0t: cipher_low expected %h got %h",
                     $time, due_head.low, out_cipher_low);
          end
        end
      end
      if (in_valid && !in_stall) begin
        // Rebuild the schedule on the first block after a key change.
        if (!schedule_valid) expand_schedule();
        cipher_due.push_back(cipher_block(in_block_high, in_block_low));
      end
    end
    blocks_due = cipher_due.size();
  end

endmodule

FILE: test/tb_sm4_variant_block_encrypt_top.sv
module tb_sm4_variant_block_encrypt_top;
  timeunit 1ns;
  timeprecision 1ps;
  import sm4v_pkg::*;

  localparam int ROUNDS         = 32;
  localparam int STALL_MAX      = 10;
  localparam int DRAIN_CYCLES   = 80;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int RANDOM_BLOCKS  = 1100;

  localparam cfg_idx_t REG_UNMAPPED_2 = 2'd2;
  localparam cfg_idx_t REG_UNMAPPED_3 = 2'd3;

  logic     clk;
  logic     rst_n;
  logic     in_valid;
  logic     in_stall;
  half_t    in_block_high;
  half_t    in_block_low;
  logic     out_valid;
  logic     out_stall;
  half_t    out_cipher_high;
  half_t    out_cipher_low;
  logic     cfg_valid;
  logic     cfg_ready;
  cfg_idx_t cfg_index;
  half_t    cfg_data;
  int       mismatches;
  int       blocks_due;
  int       idle_cycles;
  bit       no_idle;

  sm4_variant_block_encrypt_top #(.ROUND_COUNT(ROUNDS)) dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_block_high   (in_block_high),
    .in_block_low    (in_block_low),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_cipher_high (out_cipher_high),
    .out_cipher_low  (out_cipher_low),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data)
  );

  sm4v_cipher_checker #(.ROUND_COUNT(ROUNDS)) cipher_check (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_block_high   (in_block_high),
    .in_block_low    (in_block_low),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_cipher_high (out_cipher_high),
    .out_cipher_low  (out_cipher_low),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .mismatches      (mismatches),
    .blocks_due      (blocks_due)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Abort when no beat of any channel moves for too long.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("sm4_variant_block_encrypt_top regression: fail");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Result side: hold stall for a random count, then take one beat.
  initial begin
    int n;
    out_stall = 1'b0;
    @(negedge clk);
    forever begin
      n = no_idle ? 0 : $urandom_range(0, STALL_MAX);
      if (n > 0) begin
        out_stall <= 1'b1;
        repeat (n) @(negedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!out_valid);
      @(negedge clk);
    end
  end

  function automatic half_t pick_half();
    case ($urandom_range(0, 15))
      0:       return '0;
      1:       return '1;
      2:       return half_t'(1) << $urandom_range(0, HALF_W - 1);
      3:       return ~(half_t'(1) << $urandom_range(0, HALF_W - 1));
      default: return {$urandom, $urandom};
    endcase
  endfunction

  // Leaves in_valid high; the caller or the next gap lowers it.
  task automatic send_block(input half_t hi, input half_t lo);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, STALL_MAX);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid      <= 1'b1;
    in_block_high <= hi;
    in_block_low  <= lo;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
  endtask

  // Leaves cfg_valid high so back-to-back writes need no extra edge.
  task automatic cfg_write(input cfg_idx_t idx, input half_t value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    wait (blocks_due == 0);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  initial begin
    int sent;
    int phase_len;
    rst_n         = 1'b0;
    in_valid      = 1'b0;
    in_block_high = '0;
    in_block_low  = '0;
    cfg_valid     = 1'b0;
    cfg_index     = REG_KEY_HIGH;
    cfg_data      = '0;
    no_idle       = 1'b1;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Reset key of all zeros, schedule built on the first block.
    send_block('0, '0);
    send_block('1, '1);
    send_block(64'h0123456789abcdef, 64'hfedcba9876543210);
    drain();

    cfg_write(REG_KEY_HIGH, 64'h0123456789abcdef);
    cfg_write(REG_KEY_LOW, 64'hfedcba9876543210);
    cfg_valid <= 1'b0;
    send_block(64'h0123456789abcdef, 64'hfedcba9876543210);
    send_block(64'h0123456789abcdef, 64'hfedcba9876543210);
    send_block('0, '1);
    drain();

    no_idle = 1'b0;
    cfg_write(REG_KEY_HIGH, '1);
    cfg_write(REG_KEY_LOW, '1);
    cfg_valid <= 1'b0;
    send_block('1, '0);
    send_block('0, '1);
    send_block(64'h8000_0000_0000_0000, 64'h1);
    drain();

    // Unmapped indexes must leave the key and its schedule alone.
    cfg_write(REG_UNMAPPED_2, pick_half());
    cfg_write(REG_UNMAPPED_3, pick_half());
    cfg_valid <= 1'b0;
    send_block('1, '1);
    drain();

    // A single register write still forces a new schedule.
    cfg_write(REG_KEY_LOW, '0);
    cfg_valid <= 1'b0;
    send_block('0, '0);
    send_block(64'h5555_aaaa_5555_aaaa, 64'haaaa_5555_aaaa_5555);
    drain();

    cfg_write(REG_KEY_HIGH, '0);
    cfg_valid <= 1'b0;
    send_block('1, '1);
    send_block({$urandom, $urandom}, {$urandom, $urandom});

    sent = 0;
    while (sent < RANDOM_BLOCKS) begin
      drain();
      no_idle = ($urandom_range(0, 3) == 0);
      case ($urandom_range(0, 5))
        0: cfg_write(REG_KEY_HIGH, pick_half());
        1: cfg_write(REG_KEY_LOW, pick_half());
        2: begin
          cfg_write(REG_KEY_HIGH, pick_half());
          cfg_write(REG_KEY_LOW, pick_half());
        end
        3: begin
          cfg_write(REG_KEY_LOW, pick_half());
          cfg_write($urandom_range(0, 1) ? REG_UNMAPPED_2 : REG_UNMAPPED_3, pick_half());
          cfg_write(REG_KEY_HIGH, pick_half());
        end
        4: cfg_write($urandom_range(0, 1) ? REG_UNMAPPED_2 : REG_UNMAPPED_3, pick_half());
        default: ;
      endcase
      cfg_valid <= 1'b0;
      phase_len = $urandom_range(1, 40);
      for (int i = 0; i < phase_len; i++) begin
        send_block(pick_half(), pick_half());
        sent++;
      end
    end
    drain();

    if (mismatches == 0 && blocks_due == 0) begin
      $display("sm4_variant_block_encrypt_top regression: pass");
    end else begin
      $display("sm4_variant_block_encrypt_top regression: fail");
    end
    $finish;
  end

endmodule

FILE: sim.f
rtl/core/sm4v_pkg.sv
rtl/core/sm4v_round.sv
rtl/core/sm4_variant_block_encrypt_top.sv
test/sm4v_cipher_checker.sv
test/tb_sm4_variant_block_encrypt_top.sv
